FILE: hw/rtl/mvt_pkg.sv
// Shared types and constants for the 4x4 matrix-vector transform.
package mvt_pkg;

    localparam int SIDE        = 4;
    localparam int DATA_W      = 32;
    localparam int IN_TDATA_W  = 168;
    localparam int OUT_TDATA_W = 128;

    typedef logic signed [DATA_W-1:0] fix_t;
    typedef fix_t [SIDE-1:0] fix_vec_t;

    typedef enum logic
    {
        OP_LOAD      = 1'b0,
        OP_TRANSFORM = 1'b1
    } opcode_t;

    typedef struct packed
    {
        fix_t value;
        logic sat;
    } row_result_t;

endpackage

FILE: hw/rtl/mvt_row.sv
// One row dot product: product, pair-sum and saturating-sum stages.
module mvt_row
#(
    parameter int FRAC_BITS = 16,
    parameter int DIM       = 4
)
(
    input  logic             clk,
    input  logic             en,
    input  mvt_pkg::fix_vec_t mat_row,
    input  mvt_pkg::fix_vec_t vec,
    output mvt_pkg::row_result_t result
);
    import mvt_pkg::*;

    localparam int PROD_W = 2 * DATA_W;
    localparam int PART_W = PROD_W - FRAC_BITS;
    localparam int PAIR_W = PART_W + 1;
    localparam int SUM_W  = PART_W + 2;

    logic signed [PROD_W-1:0] prod_reg [SIDE];
    logic signed [PROD_W-1:0] prod_next [SIDE];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [PAIR_W-1:0] pair_next [2];
    row_result_t              result_reg;
    row_result_t              result_next;

    logic signed [PART_W-1:0] part [SIDE];
    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-DATA_W:0]    sum_hi;

    always_comb
    begin
        for (int c = 0; c < SIDE; c++)
        begin
            if (c < DIM)
                prod_next[c] = $signed(mat_row[c]) * $signed(vec[c]);
            else
                prod_next[c] = '0;
        end
    end

    // truncation toward minus infinity: drop the fraction bits
    always_comb
    begin
        for (int c = 0; c < SIDE; c++)
            part[c] = $signed(prod_reg[c][PROD_W-1:FRAC_BITS]);
        pair_next[0] = PAIR_W'(part[0]) + PAIR_W'(part[1]);
        pair_next[1] = PAIR_W'(part[2]) + PAIR_W'(part[3]);
    end

    always_comb
    begin
        sum    = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        sum_hi = sum[SUM_W-1:DATA_W-1];
        if ((&sum_hi) || !(|sum_hi))
        begin
            result_next.value = sum[DATA_W-1:0];
            result_next.sat   = 1'b0;
        end
        else
        begin
            result_next.value = sum[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                             : {1'b0, {(DATA_W-1){1'b1}}};
            result_next.sat   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < SIDE; c++)
                prod_reg[c] <= prod_next[c];
            pair_reg[0] <= pair_next[0];
            pair_reg[1] <= pair_next[1];
            result_reg  <= result_next;
        end
    end

    assign result = result_reg;

endmodule

FILE: hw/rtl/matrix_vector_transform_4x4.sv
// Top level of the 4x4 fixed-point matrix-vector transform.
// Holds a DIM x DIM matrix of signed Q(32-FRAC_BITS).FRAC_BITS entries, reset to
// the identity. A load request (tuser = 0) writes one entry and returns nothing;
// a transform request (tuser = 1) returns the four row dot products, each element
// product truncated toward minus infinity and each row sum saturated to 32 bits,
// with tuser set if any row clamped. One request is accepted every cycle while
// s_axis_tready is high; a transform result passes through the input register,
// multiplier register, pair-sum register and saturating-sum output register. The
// pipeline advances whenever the output register is empty or being taken. A load
// takes effect for every transform accepted after it.
module matrix_vector_transform_4x4
#(
    parameter int FRAC_BITS = 16,
    parameter int DIM       = 4
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // row[1:0], column[3:2], entry_value[35:4], vec_x[67:36], vec_y[99:68],
    // vec_z[131:100], vec_w[163:132], zero fill above
    input  logic [mvt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // opcode[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
    output logic [mvt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // saturated[0]
    output logic                                m_axis_tuser
);
    import mvt_pkg::*;

    logic        en;
    logic        accept;
    logic        load_hit;
    logic [1:0]  ld_row;
    logic [1:0]  ld_col;
    fix_t        ld_value;

    fix_vec_t    matrix_reg [SIDE];
    fix_vec_t    vec_reg;
    fix_vec_t    vec_next;
    logic [2:0]  valid_reg;
    logic [2:0]  valid_next;
    logic        out_valid_reg;

    row_result_t row_res [SIDE];
    logic [SIDE-1:0] row_sat;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    assign ld_row   = s_axis_tdata[1:0];
    assign ld_col   = s_axis_tdata[3:2];
    assign ld_value = s_axis_tdata[35:4];
    assign load_hit = accept && (opcode_t'(s_axis_tuser) == OP_LOAD)
                      && ({1'b0, ld_row} < 3'(DIM)) && ({1'b0, ld_col} < 3'(DIM));

    assign vec_next[0] = s_axis_tdata[67:36];
    assign vec_next[1] = s_axis_tdata[99:68];
    assign vec_next[2] = s_axis_tdata[131:100];
    assign vec_next[3] = s_axis_tdata[163:132];

    assign valid_next = {valid_reg[1:0],
                         accept && (opcode_t'(s_axis_tuser) == OP_TRANSFORM)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < SIDE; r++)
            begin
                for (int c = 0; c < SIDE; c++)
                    matrix_reg[r][c] <= (r == c) ? (fix_t'(1) <<< FRAC_BITS) : '0;
            end
        end
        else
        begin
            if (en)
            begin
                valid_reg     <= valid_next;
                out_valid_reg <= valid_reg[2];
            end
            if (load_hit)
                matrix_reg[ld_row][ld_col] <= ld_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            vec_reg <= vec_next;
    end

    for (genvar r = 0; r < SIDE; r++)
    begin : g_row
        if (r < DIM)
        begin : g_live
            mvt_row
            #(
                .FRAC_BITS (FRAC_BITS),
                .DIM       (DIM)
            )
            u_row
            (
                .clk     (clk),
                .en      (en),
                .mat_row (matrix_reg[r]),
                .vec     (vec_reg),
                .result  (row_res[r])
            );
        end
        else
        begin : g_unused
            assign row_res[r] = '0;
        end
        assign row_sat[r] = row_res[r].sat;
        assign m_axis_tdata[r*DATA_W +: DATA_W] = row_res[r].value;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = |row_sat;

endmodule
